@@ rtl/sea_pkg.sv @@
package sea_pkg;

   // Word and block geometry
   localparam int unsigned WORD_W = 16;
   localparam int unsigned HALF_W = 3 * WORD_W;
   localparam int unsigned BLK_W  = 6 * WORD_W;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_HIGH = 2'd1;

   // Input item
   typedef struct packed {
      logic        func;
      logic [63:0] block_low;
      logic [31:0] block_high;
   } req_type;

   // Result item
   typedef struct packed {
      logic [63:0] result_low;
      logic [31:0] result_high;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // capture block, seed key schedule register
      logic key_we;    // write one round key, advance key schedule
      logic rd_en;     // read one round key
      logic round_en;  // apply one round with the key just read
      logic dec;       // round direction
      logic out_load;  // move finished block into the output register
   } cmd_type;

endpackage

@@ rtl/sea_ctrl.sv @@
module sea_ctrl #(
   parameter int unsigned ROUNDS = 95,
   parameter int unsigned AW     = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_func,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               csr_we,
   input  logic [sea_pkg::CSR_ADDR_W-1:0]     csr_addr,
   output sea_pkg::cmd_type                   cmd,
   output logic [AW-1:0]                      addr
);

   localparam int unsigned CW = $clog2(ROUNDS + 1);

   sea_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               func_ff, func_in;
   logic               keys_valid_ff, keys_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]      rd_idx;
   logic               key_wr;

   assign key_wr = csr_we && (csr_addr == sea_pkg::CSR_KEY_LOW ||
                              csr_addr == sea_pkg::CSR_KEY_HIGH);

   // Store address for the round read; decryption walks the store backwards
   assign rd_idx = func_ff ? (CW'(ROUNDS - 1) - cnt_ff) : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sea_pkg::ST_IDLE;
         cnt_ff        <= '0;
         func_ff       <= 1'b0;
         keys_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         func_ff       <= func_in;
         keys_valid_ff <= keys_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      func_in       = func_ff;
      keys_valid_in = keys_valid_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.dec       = func_ff;
      addr          = cnt_ff[AW-1:0];

      // output register drains independently of the state machine
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         sea_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               func_in  = req_func;
               cnt_in   = '0;
               state_in = keys_valid_ff ? sea_pkg::ST_LOAD : sea_pkg::ST_BUILD;
            end
         end
         sea_pkg::ST_BUILD: begin
            cmd.key_we = 1'b1;
            addr       = cnt_ff[AW-1:0];
            if (cnt_ff == CW'(ROUNDS - 1)) begin
               cnt_in        = '0;
               keys_valid_in = 1'b1;
               state_in      = sea_pkg::ST_LOAD;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         sea_pkg::ST_LOAD: begin
            cmd.rd_en = 1'b1;
            addr      = rd_idx[AW-1:0];
            cnt_in    = cnt_ff + CW'(1);
            state_in  = sea_pkg::ST_ROUND;
         end
         sea_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (cnt_ff == CW'(ROUNDS)) begin
               state_in = sea_pkg::ST_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               addr      = rd_idx[AW-1:0];
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         sea_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sea_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sea_pkg::ST_IDLE;
         end
      endcase

      // a key change forces a schedule rebuild on the next item
      if (key_wr) begin
         keys_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/sea_dp.sv @@
module sea_dp #(
   parameter int unsigned ROUNDS = 95,
   parameter int unsigned AW     = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sea_pkg::req_type                   req_data,
   output sea_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [sea_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sea_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  sea_pkg::cmd_type                   cmd,
   input  logic [AW-1:0]                      addr
);

   localparam int unsigned Q  = ROUNDS >> 2;
   localparam int unsigned H  = (ROUNDS + 1) >> 2;
   localparam int unsigned HW = sea_pkg::HALF_W;
   localparam int unsigned BW = sea_pkg::BLK_W;

   // Add key, substitution layer, bit rotation on one 3-word branch
   function automatic logic [47:0] mix(input logic [47:0] x, input logic [47:0] k);
      logic [15:0] a0, a1, a2;
      begin
         a0 = x[15:0]  + k[15:0];
         a1 = x[31:16] + k[31:16];
         a2 = x[47:32] + k[47:32];
         a0 = a0 ^ (a1 & a2);
         a1 = a1 ^ (a0 & a2);
         a2 = a2 ^ (a1 | a0);
         mix = {{a2[14:0], a2[15]}, a1, {a0[0], a0[15:1]}};
      end
   endfunction

   // word 0 <- word 2, word 1 <- word 0, word 2 <- word 1
   function automatic logic [47:0] word_rot(input logic [47:0] x);
      word_rot = {x[31:16], x[15:0], x[47:32]};
   endfunction

   // word 0 <- word 1, word 1 <- word 2, word 2 <- word 0
   function automatic logic [47:0] inv_word_rot(input logic [47:0] x);
      inv_word_rot = {x[15:0], x[47:32], x[31:16]};
   endfunction

   logic [63:0]    key_low_ff;
   logic [31:0]    key_high_ff;
   logic [BW-1:0]  kreg_ff, kreg_in;
   logic [BW-1:0]  blk_ff, blk_in;
   logic [HW-1:0]  key_mem_ff [ROUNDS];
   logic [HW-1:0]  rk_ff;
   logic [BW-1:0]  out_ff;
   logic [BW-1:0]  mkey;
   logic [BW-1:0]  kstep;
   logic [AW:0]    kidx;
   logic [15:0]    cval;
   logic [HW-1:0]  kmix;
   logic [HW-1:0]  rmix;
   logic [HW-1:0]  rnew;
   logic [HW-1:0]  wr_half;

   // Master key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_we) begin
         if (csr_addr == sea_pkg::CSR_KEY_LOW) begin
            key_low_ff <= csr_wdata;
         end
         if (csr_addr == sea_pkg::CSR_KEY_HIGH) begin
            key_high_ff <= csr_wdata[31:0];
         end
      end
   end

   // Key schedule step for the entry after the one being written
   always_comb begin
      mkey = {key_high_ff, key_low_ff};
      if (Q == 0) begin
         mkey = {mkey[HW-1:0], mkey[BW-1:HW]};
      end
      kidx  = {1'b0, addr} + (AW + 1)'(1);
      cval  = (kidx <= (AW + 1)'(Q)) ? 16'(kidx) : (16'(ROUNDS) - 16'(kidx));
      kmix  = mix(kreg_ff[HW-1:0], {32'h0, cval});
      kstep = {kreg_ff[HW-1:0], word_rot(kmix) ^ kreg_ff[BW-1:HW]};
      if (kidx == (AW + 1)'(Q)) begin
         kstep = {kstep[HW-1:0], kstep[BW-1:HW]};
      end
      // only the half used by that round is kept
      wr_half = (addr < AW'(H)) ? kreg_ff[HW-1:0] : kreg_ff[BW-1:HW];

      kreg_in = kreg_ff;
      if (cmd.load) begin
         kreg_in = mkey;
      end else if (cmd.key_we) begin
         kreg_in = kstep;
      end
   end

   always_ff @(posedge clock) begin
      kreg_ff <= kreg_in;
   end

   // Round key store: one write or one read per cycle, registered read
   always_ff @(posedge clock) begin
      if (cmd.key_we) begin
         key_mem_ff[addr] <= wr_half;
      end
      if (cmd.rd_en) begin
         rk_ff <= key_mem_ff[addr];
      end
   end

   // Feistel round unit; words 0..2 are R, words 3..5 are L
   always_comb begin
      rmix = mix(blk_ff[HW-1:0], rk_ff);
      if (cmd.dec) begin
         rnew = inv_word_rot(rmix ^ blk_ff[BW-1:HW]);
      end else begin
         rnew = rmix ^ word_rot(blk_ff[BW-1:HW]);
      end

      blk_in = blk_ff;
      if (cmd.load) begin
         blk_in = {req_data.block_high, req_data.block_low};
      end else if (cmd.round_en) begin
         blk_in = {blk_ff[HW-1:0], rnew};
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   // Output register, branches swapped after the last round
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= {blk_ff[HW-1:0], blk_ff[BW-1:HW]};
      end
   end

   assign rsp_data.result_low  = out_ff[63:0];
   assign rsp_data.result_high = out_ff[95:64];

endmodule

@@ rtl/sea_block_cipher_96.sv @@
// SEA 96/96 block cipher engine. Each transfer on the req channel carries one
// 96-bit block and a func bit (0 encrypt, 1 decrypt) and produces one result on
// the rsp channel. A single round unit applies one Feistel round per cycle, and
// the round key for that round is read from a single-port key store the cycle
// before. An item passes through the accept cycle, one store read ahead of the
// first round, ROUNDS rounds and the load of the output register, which waits
// while that register still holds an untaken result. After any write to key_low
// or key_high, the next item first rebuilds the key store one entry per cycle;
// later items skip the rebuild. A finished result sits in the output register
// while the next item is taken in.
module sea_block_cipher_96 #(
   parameter int unsigned ROUNDS = 95
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  sea_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output sea_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [sea_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sea_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned AW = $clog2(ROUNDS);

   sea_pkg::cmd_type cmd;
   logic [AW-1:0]    addr;

   sea_ctrl #(
      .ROUNDS (ROUNDS),
      .AW     (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .cmd       (cmd),
      .addr      (addr)
   );

   sea_dp #(
      .ROUNDS (ROUNDS),
      .AW     (AW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .addr      (addr)
   );

   // Result shows up right after the output register is loaded
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("output load did not raise rsp_valid");

   // Block stays busy after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new item accepted while one is in flight");

   // Every key read is consumed by a round in the following cycle
   a_rd_round: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> cmd.round_en)
      else $error("round key read not followed by a round");

   // Key writes and rounds never overlap
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.key_we && (cmd.round_en || cmd.rd_en)))
      else $error("key schedule overlaps data rounds");

endmodule

@@ tb/sv/tb_sea_block_cipher_96.sv @@
`timescale 1ns / 100ps

module tb_sea_block_cipher_96;

   localparam int NUM_ROUNDS = 95;

   // func codes on the req channel
   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   // register indexes with no register behind them
   localparam logic [sea_pkg::CSR_ADDR_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [sea_pkg::CSR_ADDR_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef logic [2:0][sea_pkg::WORD_W-1:0] branch_type;
   typedef logic [5:0][sea_pkg::WORD_W-1:0] block_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   sea_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   sea_pkg::rsp_type               rsp_data;
   logic                           csr_we    = 1'b0;
   logic [sea_pkg::CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [sea_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state: key registers and the expanded schedule
   logic [63:0] key_lo     = '0;
   logic [31:0] key_hi     = '0;
   logic        keys_ready = 1'b0;
   block_type   round_keys [NUM_ROUNDS];

   sea_pkg::rsp_type expected_blocks [$];
   int      fail_count     = 0;
   int      results_seen   = 0;
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      hold_left      = 0;

   sea_block_cipher_96 #(.ROUNDS(NUM_ROUNDS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Key add, substitution, bit rotation on one branch
   function automatic branch_type sea_mix(branch_type x, branch_type k);
      branch_type y;
      for (int w = 0; w < 3; w++) y[w] = x[w] + k[w];
      y[0] = y[0] ^ (y[1] & y[2]);
      y[1] = y[1] ^ (y[0] & y[2]);
      y[2] = y[2] ^ (y[1] | y[0]);
      y[0] = {y[0][0], y[0][15:1]};
      y[2] = {y[2][14:0], y[2][15]};
      return y;
   endfunction

   function automatic branch_type sea_word_rot(branch_type x);
      return {x[1], x[0], x[2]};
   endfunction

   function automatic block_type sea_key_step(block_type src, int cval);
      branch_type c;
      c = '0;
      c[0] = 16'(cval);
      return {src[2:0], sea_word_rot(sea_mix(src[2:0], c)) ^ src[5:3]};
   endfunction

   // Expected cipher output; rebuilds the schedule after a key write
   function automatic sea_pkg::rsp_type predict_result(sea_pkg::req_type item);
      block_type        s;
      branch_type       k;
      branch_type       x;
      sea_pkg::rsp_type r;
      int               q;
      int               h;
      q = NUM_ROUNDS >> 2;
      h = (NUM_ROUNDS + 1) >> 2;
      if (!keys_ready) begin
         round_keys[0] = {key_hi, key_lo};
         for (int i = 1; i <= q; i++) round_keys[i] = sea_key_step(round_keys[i-1], i);
         // halves swap at the quarter point, as the block does it
         round_keys[q] = {round_keys[q][2:0], round_keys[q][5:3]};
         for (int i = q + 1; i < NUM_ROUNDS; i++)
            round_keys[i] = sea_key_step(round_keys[i-1], NUM_ROUNDS - i);
         keys_ready = 1'b1;
      end
      s = {item.block_high, item.block_low};
      if (item.func == FUNC_ENCRYPT) begin
         for (int i = 1; i <= NUM_ROUNDS; i++) begin
            k = (i <= h) ? round_keys[i-1][2:0] : round_keys[i-1][5:3];
            s = {s[2:0], sea_mix(s[2:0], k) ^ sea_word_rot(s[5:3])};
         end
      end else begin
         for (int i = NUM_ROUNDS; i >= 1; i--) begin
            k = (i <= h) ? round_keys[i-1][2:0] : round_keys[i-1][5:3];
            x = sea_mix(s[2:0], k) ^ s[5:3];
            s = {s[2:0], x[0], x[2], x[1]};
         end
      end
      s = {s[2:0], s[5:3]};
      r.result_low  = s[3:0];
      r.result_high = s[5:4];
      return r;
   endfunction

   // Words biased toward 0 and all ones to hit add carries
   function automatic block_type random_words();
      block_type b;
      for (int i = 0; i < 6; i++) begin
         case ($urandom_range(7))
            0: b[i] = '0;
            1: b[i] = '1;
            default: b[i] = 16'($urandom);
         endcase
      end
      return b;
   endfunction

   function automatic sea_pkg::req_type make_item(logic func, block_type b);
      sea_pkg::req_type r;
      r.func       = func;
      r.block_low  = b[3:0];
      r.block_high = b[5:4];
      return r;
   endfunction

   function automatic sea_pkg::req_type random_item();
      return make_item(1'($urandom_range(1)), random_words());
   endfunction

   // Offer one block; valid stays up after the transfer unless the next
   // call idles or drain() drops it
   task automatic send_block(input sea_pkg::req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_blocks.push_back(predict_result(item));
   endtask

   task automatic write_csr(input logic [sea_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [sea_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         sea_pkg::CSR_KEY_LOW: begin
            key_lo     = value;
            keys_ready = 1'b0;
         end
         sea_pkg::CSR_KEY_HIGH: begin
            key_hi     = value[31:0];
            keys_ready = 1'b0;
         end
         default: ;
      endcase
   endtask

   // Upper bits of the key_high write are junk and must be dropped
   task automatic set_key(input block_type k);
      write_csr(sea_pkg::CSR_KEY_LOW, k[3:0]);
      write_csr(sea_pkg::CSR_KEY_HIGH, {32'($urandom), k[5:4]});
   endtask

   task automatic drain(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Receiver: random stalls, or a counted hold-off when requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("result %0d %s: expected %h, got %h", results_seen, what, want, got);
   endtask

   // Compare every rsp transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      sea_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch("unexpected transfer", '0, rsp_data.result_low);
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_data.result_low !== want.result_low)
               report_mismatch("result_low", want.result_low, rsp_data.result_low);
            if (rsp_data.result_high !== want.result_high)
               report_mismatch("result_high", want.result_high, rsp_data.result_high);
         end
         results_seen++;
      end
   end

   // Key left at its reset value, schedule never built before
   task automatic test_reset_key();
      send_block(make_item(FUNC_ENCRYPT, '0));
      send_block(make_item(FUNC_DECRYPT, '0));
      send_block(make_item(FUNC_ENCRYPT, '1));
      send_block(make_item(FUNC_DECRYPT, '1));
      drain(4);
   endtask

   task automatic test_key_extremes();
      sea_pkg::req_type plain;
      sea_pkg::rsp_type cipher;
      set_key('1);
      send_block(make_item(FUNC_ENCRYPT, '0));
      send_block(make_item(FUNC_ENCRYPT, '1));
      send_block(make_item(FUNC_DECRYPT, '1));
      send_block(make_item(FUNC_ENCRYPT, {6{16'hAAAA}}));
      send_block(make_item(FUNC_DECRYPT, {6{16'h5555}}));
      // decrypting a predicted ciphertext must give the plaintext back
      plain  = random_item();
      plain.func = FUNC_ENCRYPT;
      cipher = predict_result(plain);
      send_block(make_item(FUNC_DECRYPT, {cipher.result_high, cipher.result_low}));
      drain(4);
      set_key('0);
      send_block(make_item(FUNC_ENCRYPT, {16'h8000, 16'h4000, 16'h0100, 16'h0010,
                                          16'h0002, 16'h0001}));
      drain(4);
      // every key word 1 against all-ones data: carry out of each word
      set_key({6{16'h0001}});
      send_block(make_item(FUNC_ENCRYPT, '1));
      send_block(make_item(FUNC_DECRYPT, '1));
      drain(4);
   endtask

   // Writes to spare indexes change nothing; single-register key writes
   task automatic test_register_index();
      write_csr(CSR_SPARE_2, {$urandom, $urandom});
      write_csr(CSR_SPARE_3, {$urandom, $urandom});
      send_block(random_item());
      send_block(random_item());
      drain(4);
      write_csr(sea_pkg::CSR_KEY_LOW, {$urandom, $urandom});
      send_block(random_item());
      drain(4);
      write_csr(sea_pkg::CSR_KEY_HIGH, {$urandom, $urandom});
      send_block(random_item());
      drain(4);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int count, input int per_key);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         if (n % per_key == 0) begin
            drain(4);
            set_key(random_words());
         end
         send_block(random_item());
      end
      drain(4);
   endtask

   // Long receiver hold-off while the sender keeps offering
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 1500;
      repeat (10) send_block(random_item());
      drain(4);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_key_extremes();
      test_register_index();
      test_random_traffic(0, 0, 420, 420);
      test_random_traffic(80, 0, 420, 420);
      test_random_traffic(0, 80, 420, 420);
      test_random_traffic(25, 25, 420, 420);
      test_random_traffic(25, 25, 150, 25);
      test_output_backpressure();
      drain(2 * NUM_ROUNDS);
      if (fail_count == 0)
         $display("sea_block_cipher_96: match");
      else
         $display("sea_block_cipher_96: mismatch");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("sea_block_cipher_96: mismatch");
      $finish;
   end

endmodule
